### rtl/two_level_channel_allocator_unit_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef TWO_LEVEL_CHANNEL_ALLOCATOR_UNIT_ASSERT_SVH
`define TWO_LEVEL_CHANNEL_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TLCA_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TLCA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tlca_pkg.sv
`default_nettype none

package tlca_pkg;

    // Default sizes
    localparam int DEF_DEVICES  = 8;
    localparam int DEF_MODULES  = 8;
    localparam int DEF_CHANNELS = 32;

    // Widest bit map the search function handles
    localparam int PICK_W = 32;

    typedef enum logic
    {
        OP_REQUEST = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_NO_SPACE  = 2'd1,
        STATUS_NOT_ALLOC = 2'd2
    } status_t;

    // Input item
    typedef struct packed
    {
        op_t        operation;
        logic [2:0] device;
        logic [2:0] release_module;
        logic [4:0] release_channel;
    } cmd_t;

    // Result item
    typedef struct packed
    {
        status_t    status;
        logic [2:0] got_module;
        logic [4:0] got_channel;
        logic       module_created;
        logic       module_destroyed;
    } result_t;

    typedef struct packed
    {
        logic       found;
        logic [4:0] idx;
    } pick_t;

    // Lowest clear bit of map among the bits set in mask
    function automatic pick_t lowest_free(input logic [PICK_W-1:0] map,
                                          input logic [PICK_W-1:0] mask);
        logic [PICK_W-1:0] avail;
        logic [PICK_W-1:0] first;
        pick_t             pick;
        avail = ~map & mask;
        first = avail & (~avail + PICK_W'(1));
        pick.found = |avail;
        pick.idx   = '0;
        for (int i = 0; i < PICK_W; i++)
        begin
            if (first[i])
            begin
                pick.idx = pick.idx | 5'(i);
            end
        end
        return pick;
    endfunction

endpackage

`default_nettype wire

### rtl/tlca_map_mem.sv
`default_nettype none

// Channel-map storage: one write port, one registered read port
module tlca_map_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/two_level_channel_allocator_unit.sv
`default_nettype none
// Two-level channel allocator. An item is taken when start is high and busy is low;
// its single result shows on result for exactly one cycle with done high and cannot
// be held off, so the user must capture it then. Channel maps live in a
// single-port-per-direction memory; a request walks the device's module rows one per
// cycle and then writes back, and busy stays high until an item is finished, so no
// new item is taken while one is in flight. The open-module bits are flip-flops that
// reset clears, and a row whose bit is clear reads as empty, so no clearing pass is
// needed after reset.
`include "two_level_channel_allocator_unit_assert.svh"

module two_level_channel_allocator_unit #(
    parameter int DEVICES  = tlca_pkg::DEF_DEVICES,
    parameter int MODULES  = tlca_pkg::DEF_MODULES,
    parameter int CHANNELS = tlca_pkg::DEF_CHANNELS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tlca_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output tlca_pkg::result_t result
);

    import tlca_pkg::*;

    localparam int DEV_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int MI_W  = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = DEVICES * MODULES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [CHANNELS-1:0] CH_FULL  = '1;
    localparam logic [MODULES-1:0]  MOD_FULL = '1;
    localparam logic [MI_W-1:0]     LAST_MOD = MI_W'(MODULES - 1);

    typedef enum logic [5:0]
    {
        ST_IDLE   = 6'b000001,
        ST_RD     = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_OPEN   = 6'b001000,
        ST_REQ_WR = 6'b010000,
        ST_REL    = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [MI_W-1:0]      chk_m_reg, chk_m_next;
    logic [CHANNELS-1:0]  word_reg, word_next;
    logic                 done_reg, done_next;
    result_t              result_reg, result_next;
    logic [MODULES-1:0]   module_map_reg [DEVICES];

    // memory ports
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [CHANNELS-1:0]  rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [CHANNELS-1:0]  wr_data;

    // open-module row update
    logic                 mm_we;
    logic [MODULES-1:0]   mm_row_next;

    logic                 accept;
    logic                 dev_ok;
    logic                 rel_ok;
    logic [DEV_W-1:0]     dev_idx;
    logic [MI_W-1:0]      rmod_idx;
    logic [CH_W-1:0]      ch_idx;
    logic [AW-1:0]        row_base;
    logic [MODULES-1:0]   dev_row;
    logic [MI_W-1:0]      sel_m;
    logic [MI_W-1:0]      chk_m_inc;
    logic [CHANNELS-1:0]  row_word;
    logic [CHANNELS-1:0]  rel_bit;
    logic [CHANNELS-1:0]  rel_word;
    pick_t                ch_pick;
    pick_t                mod_pick;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    tlca_map_mem #(
        .DEPTH (DEPTH),
        .WIDTH (CHANNELS),
        .AW    (AW)
    ) u_map_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // decode of the held item
    assign dev_ok   = int'(cmd_reg.device) < DEVICES;
    assign rel_ok   = dev_ok && (int'(cmd_reg.release_module) < MODULES)
                      && (int'(cmd_reg.release_channel) < CHANNELS);
    assign dev_idx  = DEV_W'(cmd_reg.device);
    assign rmod_idx = MI_W'(cmd_reg.release_module);
    assign ch_idx   = CH_W'(cmd_reg.release_channel);
    assign row_base = AW'(int'(dev_idx) * MODULES);
    assign dev_row  = module_map_reg[dev_idx];

    // row read back; a closed module reads as empty
    assign sel_m     = (state_reg == ST_REL) ? rmod_idx : chk_m_reg;
    assign chk_m_inc = chk_m_reg + MI_W'(1);
    assign row_word  = dev_row[sel_m] ? rd_data : '0;
    assign rel_bit   = CHANNELS'(1) << ch_idx;
    assign rel_word  = row_word & ~rel_bit;

    // lowest free channel of the held row, lowest closed module of the device
    assign ch_pick  = lowest_free(PICK_W'(word_reg), PICK_W'(CH_FULL));
    assign mod_pick = lowest_free(PICK_W'(dev_row), PICK_W'(MOD_FULL));

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        chk_m_next  = chk_m_reg;
        word_next   = word_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        rd_en       = 1'b0;
        rd_addr     = row_base;
        wr_en       = 1'b0;
        wr_addr     = row_base;
        wr_data     = '0;
        mm_we       = 1'b0;
        mm_row_next = dev_row;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RD;
                end
            end

            // range check, first row read
            ST_RD:
            begin
                result_next = '0;
                if (cmd_reg.operation == OP_REQUEST)
                begin
                    if (!dev_ok)
                    begin
                        result_next.status = STATUS_NO_SPACE;
                        done_next          = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = row_base;
                        chk_m_next = '0;
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    if (!rel_ok)
                    begin
                        result_next.status = STATUS_NOT_ALLOC;
                        done_next          = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = row_base + AW'(rmod_idx);
                        state_next = ST_REL;
                    end
                end
            end

            // look for a partly used module, next row read in flight
            ST_SCAN:
            begin
                if ((row_word != '0) && (row_word != CH_FULL))
                begin
                    word_next  = row_word;
                    state_next = ST_REQ_WR;
                end
                else if (chk_m_reg == LAST_MOD)
                begin
                    state_next = ST_OPEN;
                end
                else
                begin
                    chk_m_next = chk_m_inc;
                    rd_en      = 1'b1;
                    rd_addr    = row_base + AW'(chk_m_inc);
                end
            end

            // grant lowest free channel of the found module
            ST_REQ_WR:
            begin
                wr_en                   = 1'b1;
                wr_addr                 = row_base + AW'(chk_m_reg);
                wr_data                 = word_reg | (CHANNELS'(1) << ch_pick.idx);
                result_next.status      = STATUS_OK;
                result_next.got_module  = 3'(chk_m_reg);
                result_next.got_channel = ch_pick.idx;
                done_next               = 1'b1;
                state_next              = ST_IDLE;
            end

            // open the lowest closed module with channel 0, else report no space
            ST_OPEN:
            begin
                if (!mod_pick.found)
                begin
                    result_next.status = STATUS_NO_SPACE;
                end
                else
                begin
                    wr_en                      = 1'b1;
                    wr_addr                    = row_base + AW'(MI_W'(mod_pick.idx));
                    wr_data                    = CHANNELS'(1);
                    mm_we                      = 1'b1;
                    mm_row_next                = dev_row | (MODULES'(1) << mod_pick.idx);
                    result_next.status         = STATUS_OK;
                    result_next.got_module     = 3'(mod_pick.idx);
                    result_next.module_created = 1'b1;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            // clear the channel, close the module when it empties; a channel not held reports not allocated
            ST_REL:
            begin
                if ((row_word & rel_bit) == '0)
                begin
                    result_next.status = STATUS_NOT_ALLOC;
                end
                else
                begin
                    wr_en              = 1'b1;
                    wr_addr            = row_base + AW'(rmod_idx);
                    wr_data            = rel_word;
                    result_next.status = STATUS_OK;
                    if (rel_word == '0)
                    begin
                        mm_we                        = 1'b1;
                        mm_row_next                  = dev_row & ~(MODULES'(1) << rmod_idx);
                        result_next.module_destroyed = 1'b1;
                    end
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            chk_m_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            chk_m_reg <= chk_m_next;
        end
    end

    // open-module bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DEVICES; d++)
            begin
                module_map_reg[d] <= '0;
            end
        end
        else if (mm_we)
        begin
            module_map_reg[dev_idx] <= mm_row_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        word_reg   <= word_next;
        result_reg <= result_next;
    end

    // checks
    `TLCA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done,
        "accepted item did not start the sequencer")
    `TLCA_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy,
        "result strobe while sequencer still busy")
    `TLCA_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done,
        "result strobe lasted more than one cycle")
    `TLCA_ASSERT_SAME(a_create_ok, clk, rst_n, done && result.module_created,
        result.status == STATUS_OK && !result.module_destroyed,
        "module opened without a clean grant")

endmodule

`default_nettype wire

### verif/tb_two_level_channel_allocator_unit.sv
`default_nettype none

module tb_two_level_channel_allocator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import tlca_pkg::*;

    localparam int NUM_DEV  = DEF_DEVICES;
    localparam int NUM_MOD  = DEF_MODULES;
    localparam int NUM_CHAN = DEF_CHANNELS;
    localparam int RANDOM_ITEMS = 1750;

    // Shadow copy of the allocation maps plus the queue of expected grants
    class alloc_scoreboard;
        logic [NUM_CHAN-1:0] chan_map [NUM_DEV][NUM_MOD];
        logic [NUM_MOD-1:0]  open_mods [NUM_DEV];
        result_t             pending [$];
        int                  errors;

        function new();
            foreach (chan_map[d, m])
            begin
                chan_map[d][m] = '0;
            end
            foreach (open_mods[d])
            begin
                open_mods[d] = '0;
            end
            errors = 0;
        endfunction

        // Work out the grant or release outcome for an accepted item
        function void note_command(input cmd_t c);
            result_t r;
            int      d;
            int      m;
            int      ch;
            bit      found;
            r = '0;
            r.status = STATUS_OK;
            d = int'(c.device);
            m = int'(c.release_module);
            ch = int'(c.release_channel);
            found = 1'b0;
            if (c.operation == OP_REQUEST)
            begin
                if (d >= NUM_DEV)
                begin
                    r.status = STATUS_NO_SPACE;
                end
                else
                begin
                    // first partly used module, lowest free channel
                    for (int mi = 0; mi < NUM_MOD && !found; mi++)
                    begin
                        if (chan_map[d][mi] != '0 && chan_map[d][mi] != '1)
                        begin
                            for (int ci = 0; ci < NUM_CHAN && !found; ci++)
                            begin
                                if (!chan_map[d][mi][ci])
                                begin
                                    chan_map[d][mi][ci] = 1'b1;
                                    r.got_module  = 3'(mi);
                                    r.got_channel = 5'(ci);
                                    found = 1'b1;
                                end
                            end
                        end
                    end
                    // otherwise open the lowest closed slot
                    for (int fi = 0; fi < NUM_MOD && !found; fi++)
                    begin
                        if (!open_mods[d][fi])
                        begin
                            open_mods[d][fi] = 1'b1;
                            chan_map[d][fi]  = NUM_CHAN'(1);
                            r.got_module     = 3'(fi);
                            r.got_channel    = '0;
                            r.module_created = 1'b1;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        r.status = STATUS_NO_SPACE;
                    end
                end
            end
            else
            begin
                if (d >= NUM_DEV || m >= NUM_MOD || ch >= NUM_CHAN)
                begin
                    r.status = STATUS_NOT_ALLOC;
                end
                else if (!chan_map[d][m][ch])
                begin
                    r.status = STATUS_NOT_ALLOC;
                end
                else
                begin
                    chan_map[d][m][ch] = 1'b0;
                    if (chan_map[d][m] == '0)
                    begin
                        open_mods[d][m] = 1'b0;
                        r.module_destroyed = 1'b1;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(input result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $error("result with nothing outstanding: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.got_module !== want.got_module)
            begin
                $error("got_module: expected %0d, got %0d", want.got_module, got.got_module);
                errors++;
            end
            if (got.got_channel !== want.got_channel)
            begin
                $error("got_channel: expected %0d, got %0d", want.got_channel,
                       got.got_channel);
                errors++;
            end
            if (got.module_created !== want.module_created)
            begin
                $error("module_created: expected %0d, got %0d", want.module_created,
                       got.module_created);
                errors++;
            end
            if (got.module_destroyed !== want.module_destroyed)
            begin
                $error("module_destroyed: expected %0d, got %0d", want.module_destroyed,
                       got.module_destroyed);
                errors++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    cmd_t    cmd;
    logic    busy;
    logic    done;
    result_t result;

    alloc_scoreboard sb = new();
    int idle_pct;
    int idle_by_phase [4] = '{0, 63, 0, 10};

    two_level_channel_allocator_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Watch both sides of the block at each edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                sb.check_result(result);
            end
            if (start && !busy)
            begin
                sb.note_command(cmd);
            end
        end
    end

    // Idle cycles before the next item
    function automatic int next_gap();
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            return $urandom_range(1, 14);
        end
        return 0;
    endfunction

    function automatic cmd_t make_cmd(input op_t op, input int dev, input int md,
                                      input int ch);
        cmd_t c;
        c.operation       = op;
        c.device          = 3'(dev);
        c.release_module  = 3'(md);
        c.release_channel = 5'(ch);
        return c;
    endfunction

    // Request with junk in the ignored release fields
    function automatic cmd_t make_request(input int dev);
        return make_cmd(OP_REQUEST, dev, $urandom_range(0, 7), $urandom_range(0, 31));
    endfunction

    // Release of a channel currently held on dev, else a random one
    function automatic cmd_t make_owned_release(input int dev);
        cmd_t c;
        int   held;
        int   k;
        c = make_cmd(OP_RELEASE, dev, $urandom_range(0, 7), $urandom_range(0, 31));
        held = 0;
        for (int m = 0; m < NUM_MOD; m++)
        begin
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                held += sb.chan_map[dev][m][ch];
            end
        end
        if (held > 0)
        begin
            k = $urandom_range(0, held - 1);
            for (int m = 0; m < NUM_MOD; m++)
            begin
                for (int ch = 0; ch < NUM_CHAN; ch++)
                begin
                    if (sb.chan_map[dev][m][ch])
                    begin
                        if (k == 0)
                        begin
                            c.release_module  = 3'(m);
                            c.release_channel = 5'(ch);
                        end
                        k--;
                    end
                end
            end
        end
        return c;
    endfunction

    // Present one item and hold it until the block takes it
    task automatic issue(input cmd_t c, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    initial
    begin
        cmd_t c;
        int   issued;
        int   kind;
        int   dev;
        int   len;

        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        idle_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: open, grow, hole refill, double release, close, reopen
        issue(make_cmd(OP_REQUEST, 0, 0, 0), 0);
        issue(make_cmd(OP_REQUEST, 0, 7, 31), 0);
        issue(make_cmd(OP_RELEASE, 0, 0, 0), 0);
        issue(make_cmd(OP_RELEASE, 0, 0, 0), 0);
        issue(make_cmd(OP_RELEASE, 0, 0, 1), 2);
        issue(make_cmd(OP_RELEASE, 0, 0, 1), 0);
        issue(make_cmd(OP_REQUEST, 7, 7, 31), 0);
        issue(make_cmd(OP_RELEASE, 7, 7, 31), 1);
        issue(make_cmd(OP_REQUEST, 0, 0, 0), 0);
        issue(make_cmd(OP_REQUEST, 7, 5, 10), 0);
        issue(make_cmd(OP_REQUEST, 7, 2, 21), 0);
        issue(make_cmd(OP_RELEASE, 7, 0, 0), 3);
        issue(make_cmd(OP_REQUEST, 7, 0, 0), 0);
        issue(make_cmd(OP_RELEASE, 5, 3, 17), 0);
        issue(make_cmd(OP_REQUEST, 5, 4, 14), 0);
        issue(make_cmd(OP_RELEASE, 5, 0, 31), 0);
        issue(make_cmd(OP_RELEASE, 5, 0, 0), 0);
        issue(make_cmd(OP_RELEASE, 3, 6, 8), 0);

        // Random bursts: fills, drains, mixed traffic and noise
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            dev  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 1);
            case (kind)
                0, 1:    len = $urandom_range(100, 280);
                2, 3, 4: len = $urandom_range(10, 80);
                9:       len = $urandom_range(5, 20);
                default: len = $urandom_range(20, 60);
            endcase
            for (int i = 0; i < len && issued < RANDOM_ITEMS; i++)
            begin
                idle_pct = idle_by_phase[issued * 4 / RANDOM_ITEMS];
                case (kind)
                    // fill toward no space
                    0, 1:
                    begin
                        if ($urandom_range(0, 19) == 0)
                            c = make_owned_release(dev);
                        else
                            c = make_request(dev);
                    end
                    // drain, leaving holes and closing modules
                    2, 3, 4:
                    begin
                        if ($urandom_range(0, 6) == 0)
                            c = make_request(dev);
                        else
                            c = make_owned_release(dev);
                    end
                    // anything goes
                    9:
                    begin
                        c = make_cmd($urandom_range(0, 1) ? OP_RELEASE : OP_REQUEST,
                                     $urandom_range(0, 7), $urandom_range(0, 7),
                                     $urandom_range(0, 31));
                    end
                    default:
                    begin
                        if ($urandom_range(0, 9) == 0)
                            c = make_cmd(OP_RELEASE, dev, $urandom_range(0, 7),
                                         $urandom_range(0, 31));
                        else if ($urandom_range(0, 1) == 0)
                            c = make_request(dev);
                        else
                            c = make_owned_release(dev);
                    end
                endcase
                issue(c, next_gap());
                issued++;
            end
        end
        start <= 1'b0;

        // Drain outstanding results, then let the block settle
        for (int t = 0; t < 2000 && sb.pending.size() != 0; t++)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.errors++;
        end

        if (sb.errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/tlca_pkg.sv
rtl/tlca_map_mem.sv
rtl/two_level_channel_allocator_unit.sv
verif/tb_two_level_channel_allocator_unit.sv
